>>> src/bjsd_pkg.sv
// Shared types, event codes and error codes for the binary JSON stream decoder.
// No dependencies; every other file of the decoder imports this package.
`timescale 1ns / 1ps
package bjsd_pkg;

   localparam int MAX_DEPTH = 256;
   localparam int STACK_AW  = $clog2(MAX_DEPTH);
   localparam int DEPTH_W   = $clog2(MAX_DEPTH + 1);
   localparam int LIMIT_W   = 9;
   localparam int QUEUE_DEPTH = 4;
   localparam int QUEUE_AW    = $clog2(QUEUE_DEPTH);

   localparam logic [3:0] EV_SINT    = 4'd0;
   localparam logic [3:0] EV_UINT    = 4'd1;
   localparam logic [3:0] EV_F32     = 4'd2;
   localparam logic [3:0] EV_F64     = 4'd3;
   localparam logic [3:0] EV_BIGNUM  = 4'd4;
   localparam logic [3:0] EV_NULL    = 4'd5;
   localparam logic [3:0] EV_BOOL    = 4'd6;
   localparam logic [3:0] EV_STRBYTE = 4'd7;
   localparam logic [3:0] EV_STREND  = 4'd8;
   localparam logic [3:0] EV_ARR     = 4'd9;
   localparam logic [3:0] EV_OBJ     = 4'd10;
   localparam logic [3:0] EV_END     = 4'd11;
   localparam logic [3:0] EV_DONE    = 4'd12;
   localparam logic [3:0] EV_ERROR   = 4'd13;

   localparam logic [3:0] ERR_INCOMPLETE = 4'd0;
   localparam logic [3:0] ERR_UNCLOSED   = 4'd1;
   localparam logic [3:0] ERR_TOO_DEEP   = 4'd2;
   localparam logic [3:0] ERR_UNBALANCED = 4'd3;
   localparam logic [3:0] ERR_NEED_NAME  = 4'd4;
   localparam logic [3:0] ERR_NEED_VALUE = 4'd5;
   localparam logic [3:0] ERR_INVALID    = 4'd6;
   localparam logic [3:0] ERR_RANGE      = 4'd7;
   localparam logic [3:0] ERR_EMPTY      = 4'd8;
   localparam logic [3:0] ERR_TRAILING   = 4'd9;

   localparam logic [7:0] TC_SMALL_MAX = 8'hc8;
   localparam logic [7:0] TC_BIGNUM    = 8'hca;
   localparam logic [7:0] TC_F32       = 8'hcb;
   localparam logic [7:0] TC_F64       = 8'hcc;
   localparam logic [7:0] TC_NULL      = 8'hcd;
   localparam logic [7:0] TC_FALSE     = 8'hce;
   localparam logic [7:0] TC_TRUE      = 8'hcf;
   localparam logic [7:0] TC_STR0      = 8'hd0;
   localparam logic [7:0] TC_ARRAY     = 8'hfc;
   localparam logic [7:0] TC_OBJECT    = 8'hfd;
   localparam logic [7:0] TC_CEND      = 8'hfe;
   localparam logic [7:0] TC_LSTR      = 8'hff;

   typedef struct packed {
      logic       kind;
      logic [7:0] data_byte;
   } req_type;

   typedef struct packed {
      logic [3:0]         event_res;
      logic [63:0]        value;
      logic signed [31:0] exponent;
      logic               negative;
      logic               is_name;
      logic [3:0]         error_code;
   } rsp_type;

   // One or two events produced by one byte, handed to the queue.
   typedef struct packed {
      logic    first_valid;
      logic    second_valid;
      rsp_type first;
      rsp_type second;
   } push_type;

   function automatic rsp_type make_event(input logic [3:0] ev, input logic [63:0] val,
                                          input logic [31:0] ex, input logic neg,
                                          input logic nm, input logic [3:0] code);
      rsp_type r;
      r.event_res  = ev;
      r.value      = val;
      r.exponent   = ex;
      r.negative   = neg;
      r.is_name    = nm;
      r.error_code = code;
      return r;
   endfunction

endpackage

>>> src/bjsd_front.sv
// Front end of the decoder: accepts bytes, tracks tokens and the container stack.
// Depends on bjsd_pkg; feeds bjsd_queue.
`timescale 1ns / 1ps
module bjsd_front
   import bjsd_pkg::*;
(
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 fire,
   input  req_type              item,
   input  logic [LIMIT_W-1:0]   depth_limit,
   output push_type             push
);

   typedef enum logic [3:0] {
      PH_IDLE, PH_UINT, PH_SINT, PH_F32, PH_F64, PH_BEXP, PH_BLEN, PH_BMAG,
      PH_SSTR, PH_LSTR, PH_SNAME, PH_LNAME
   } phase_type;

   phase_type            ph_ff, ph_in;
   logic [3:0]           left_ff, left_in;
   logic [63:0]          acc_ff, acc_in;
   logic [6:0]           shift_ff, shift_in;
   logic [31:0]          hexp_ff, hexp_in;
   logic                 hsign_ff, hsign_in;
   logic [DEPTH_W-1:0]   depth_ff, depth_in;
   logic                 expn_ff, expn_in;
   logic                 started_ff, started_in;
   logic                 done_ff, done_in;
   logic                 err_ff, err_in;
   logic                 top_ff, top_in;
   logic                 under_ff;

   logic                 stack_mem [MAX_DEPTH];
   logic                 stack_we;
   logic                 stack_wd;

   logic [7:0]           b;
   logic [63:0]          acc_fix;
   logic [63:0]          acc_leb;
   logic [6:0]           shift_fix;
   logic [6:0]           shift_leb;
   logic [3:0]           left_dec;
   logic [63:0]          mag;
   logic [DEPTH_W-1:0]   lim;
   logic                 vdone;
   logic                 nm;
   logic [DEPTH_W-1:0]   under_addr;

   assign b = item.data_byte;
   assign acc_fix   = acc_ff | (64'(b) << {shift_ff[5:3], 3'b000});
   assign shift_fix = shift_ff + 7'd8;
   assign acc_leb   = acc_ff | (64'(b[6:0]) << shift_ff[5:0]);
   assign shift_leb = shift_ff + 7'd7;
   assign left_dec  = (left_ff != 4'd0) ? left_ff - 4'd1 : 4'd0;
   assign mag       = acc_leb[0] ? (acc_leb >> 1) + 64'd1 : (acc_leb >> 1);
   assign lim = (depth_limit > LIMIT_W'(MAX_DEPTH)) ? DEPTH_W'(MAX_DEPTH)
                                                    : DEPTH_W'(depth_limit);
   assign under_addr = depth_in - DEPTH_W'(2);

   always_comb begin
      ph_in = ph_ff;  left_in = left_ff;  acc_in = acc_ff;  shift_in = shift_ff;
      hexp_in = hexp_ff;  hsign_in = hsign_ff;  depth_in = depth_ff;
      expn_in = expn_ff;  started_in = started_ff;  done_in = done_ff;
      err_in = err_ff;  top_in = top_ff;
      stack_we = 1'b0;  stack_wd = 1'b0;
      vdone = 1'b0;
      nm = (ph_ff == PH_SNAME) || (ph_ff == PH_LNAME);
      push = '0;
      if (fire) begin
         if (item.kind) begin
            if (!err_ff) begin
               push.first_valid = 1'b1;
               if (!started_ff)
                  push.first = make_event(EV_ERROR, '0, '0, 1'b0, 1'b0, ERR_EMPTY);
               else if (done_ff)
                  push.first = make_event(EV_DONE, '0, '0, 1'b0, 1'b0, ERR_INCOMPLETE);
               else if (ph_ff == PH_IDLE && depth_ff != '0)
                  push.first = make_event(EV_ERROR, '0, '0, 1'b0, 1'b0, ERR_UNCLOSED);
               else
                  push.first = make_event(EV_ERROR, '0, '0, 1'b0, 1'b0, ERR_INCOMPLETE);
            end
            ph_in = PH_IDLE;  left_in = '0;  acc_in = '0;  shift_in = '0;
            hexp_in = '0;  hsign_in = 1'b0;  depth_in = '0;  expn_in = 1'b0;
            started_in = 1'b0;  done_in = 1'b0;  err_in = 1'b0;
         end else if (err_ff) begin
            // Bytes after an error are dropped until the end of the document.
         end else if (done_ff) begin
            push.first_valid = 1'b1;
            push.first = make_event(EV_ERROR, '0, '0, 1'b0, 1'b0, ERR_TRAILING);
            err_in = 1'b1;  ph_in = PH_IDLE;
         end else begin
            started_in = 1'b1;
            case (ph_ff)
               PH_IDLE: begin
                  if (b == TC_CEND) begin
                     push.first_valid = 1'b1;
                     if (depth_ff == '0) begin
                        push.first = make_event(EV_ERROR, '0, '0, 1'b0, 1'b0,
                                                ERR_UNBALANCED);
                        err_in = 1'b1;
                     end else if (top_ff && !expn_ff) begin
                        push.first = make_event(EV_ERROR, '0, '0, 1'b0, 1'b0,
                                                ERR_NEED_VALUE);
                        err_in = 1'b1;
                     end else begin
                        push.first = make_event(EV_END, '0, '0, 1'b0, 1'b0, ERR_INCOMPLETE);
                        depth_in = depth_ff - DEPTH_W'(1);
                        top_in = under_ff;
                        expn_in = 1'b0;
                        if (depth_ff == DEPTH_W'(1))
                           done_in = 1'b1;
                        else if (under_ff)
                           expn_in = 1'b1;
                     end
                  end else if (depth_ff != '0 && top_ff && expn_ff) begin
                     if (b[7:4] == TC_STR0[7:4]) begin
                        if (b == TC_STR0) begin
                           push.first_valid = 1'b1;
                           push.first = make_event(EV_STREND, '0, '0, 1'b0, 1'b1,
                                                   ERR_INCOMPLETE);
                           expn_in = 1'b0;
                        end else begin
                           ph_in = PH_SNAME;  left_in = b[3:0];
                           acc_in = '0;  shift_in = '0;
                        end
                     end else if (b == TC_LSTR) begin
                        ph_in = PH_LNAME;
                     end else begin
                        push.first_valid = 1'b1;
                        push.first = make_event(EV_ERROR, '0, '0, 1'b0, 1'b0, ERR_NEED_NAME);
                        err_in = 1'b1;
                     end
                  end else if (b <= TC_SMALL_MAX) begin
                     push.first_valid = 1'b1;
                     push.first = make_event(EV_SINT, 64'(b) - 64'd100, '0, 1'b0, 1'b0,
                                             ERR_INCOMPLETE);
                     vdone = 1'b1;
                  end else begin
                     case (b) inside
                        TC_BIGNUM: begin
                           ph_in = PH_BEXP;  left_in = '0;  acc_in = '0;  shift_in = '0;
                        end
                        TC_F32: begin
                           ph_in = PH_F32;  left_in = 4'd4;  acc_in = '0;  shift_in = '0;
                        end
                        TC_F64: begin
                           ph_in = PH_F64;  left_in = 4'd8;  acc_in = '0;  shift_in = '0;
                        end
                        TC_NULL, TC_FALSE, TC_TRUE, TC_STR0: begin
                           push.first_valid = 1'b1;
                           if (b == TC_NULL)
                              push.first = make_event(EV_NULL, '0, '0, 1'b0, 1'b0,
                                                      ERR_INCOMPLETE);
                           else if (b == TC_STR0)
                              push.first = make_event(EV_STREND, '0, '0, 1'b0, 1'b0,
                                                      ERR_INCOMPLETE);
                           else
                              push.first = make_event(EV_BOOL, 64'(b == TC_TRUE), '0, 1'b0,
                                                      1'b0, ERR_INCOMPLETE);
                           vdone = 1'b1;
                        end
                        TC_ARRAY, TC_OBJECT: begin
                           push.first_valid = 1'b1;
                           if (depth_ff >= lim) begin
                              push.first = make_event(EV_ERROR, '0, '0, 1'b0, 1'b0,
                                                      ERR_TOO_DEEP);
                              err_in = 1'b1;
                           end else begin
                              push.first = make_event(b[0] ? EV_OBJ : EV_ARR, '0, '0,
                                                      1'b0, 1'b0, ERR_INCOMPLETE);
                              stack_we = 1'b1;  stack_wd = b[0];
                              depth_in = depth_ff + DEPTH_W'(1);
                              top_in = b[0];  expn_in = b[0];
                           end
                        end
                        TC_LSTR: ph_in = PH_LSTR;
                        [8'hd1:8'hdf]: begin
                           ph_in = PH_SSTR;  left_in = b[3:0];  acc_in = '0;  shift_in = '0;
                        end
                        [8'he0:8'he7]: begin
                           ph_in = b[2] ? PH_SINT : PH_UINT;
                           left_in = 4'd1 << b[1:0];  acc_in = '0;  shift_in = '0;
                        end
                        default: begin
                           push.first_valid = 1'b1;
                           push.first = make_event(EV_ERROR, '0, '0, 1'b0, 1'b0, ERR_INVALID);
                           err_in = 1'b1;
                        end
                     endcase
                  end
               end
               PH_UINT, PH_SINT, PH_F32, PH_F64, PH_BMAG: begin
                  acc_in = acc_fix;  shift_in = shift_fix;  left_in = left_dec;
                  if (left_dec == 4'd0) begin
                     push.first_valid = 1'b1;
                     vdone = 1'b1;
                     case (ph_ff)
                        PH_UINT:
                           push.first = make_event(EV_UINT, acc_fix, '0, 1'b0, 1'b0,
                                                   ERR_INCOMPLETE);
                        PH_SINT: begin
                           case (shift_fix)
                              7'd8:  acc_in = {{56{acc_fix[7]}}, acc_fix[7:0]};
                              7'd16: acc_in = {{48{acc_fix[15]}}, acc_fix[15:0]};
                              7'd32: acc_in = {{32{acc_fix[31]}}, acc_fix[31:0]};
                              default: acc_in = acc_fix;
                           endcase
                           push.first = make_event(EV_SINT, acc_in, '0, 1'b0, 1'b0,
                                                   ERR_INCOMPLETE);
                        end
                        PH_F32: begin
                           if (acc_fix[30:23] == 8'hff) begin
                              push.first = make_event(EV_ERROR, '0, '0, 1'b0, 1'b0,
                                                      ERR_INVALID);
                              vdone = 1'b0;  err_in = 1'b1;  ph_in = PH_IDLE;
                           end else
                              push.first = make_event(EV_F32, acc_fix, '0, 1'b0, 1'b0,
                                                      ERR_INCOMPLETE);
                        end
                        PH_F64: begin
                           if (acc_fix[62:52] == 11'h7ff) begin
                              push.first = make_event(EV_ERROR, '0, '0, 1'b0, 1'b0,
                                                      ERR_INVALID);
                              vdone = 1'b0;  err_in = 1'b1;  ph_in = PH_IDLE;
                           end else
                              push.first = make_event(EV_F64, acc_fix, '0, 1'b0, 1'b0,
                                                      ERR_INCOMPLETE);
                        end
                        default: begin
                           if (b == 8'h00) begin
                              push.first = make_event(EV_ERROR, '0, '0, 1'b0, 1'b0,
                                                      ERR_INVALID);
                              vdone = 1'b0;  err_in = 1'b1;  ph_in = PH_IDLE;
                           end else
                              push.first = make_event(EV_BIGNUM, acc_fix, hexp_ff, hsign_ff,
                                                      1'b0, ERR_INCOMPLETE);
                        end
                     endcase
                  end
               end
               PH_BEXP, PH_BLEN: begin
                  acc_in = acc_leb;
                  if (b[7]) begin
                     shift_in = shift_leb;
                     if (shift_leb[6]) begin
                        push.first_valid = 1'b1;
                        push.first = make_event(EV_ERROR, '0, '0, 1'b0, 1'b0, ERR_RANGE);
                        err_in = 1'b1;  ph_in = PH_IDLE;
                     end
                  end else if (ph_ff == PH_BEXP) begin
                     hexp_in = acc_leb[32:1] ^ {32{acc_leb[0]}};
                     ph_in = PH_BLEN;  left_in = '0;  acc_in = '0;  shift_in = '0;
                  end else if (mag == 64'd0) begin
                     push.first_valid = 1'b1;
                     push.first = make_event(EV_BIGNUM, '0, hexp_ff, 1'b0, 1'b0,
                                             ERR_INCOMPLETE);
                     vdone = 1'b1;
                  end else if (mag > 64'd8) begin
                     push.first_valid = 1'b1;
                     push.first = make_event(EV_ERROR, '0, '0, 1'b0, 1'b0, ERR_RANGE);
                     err_in = 1'b1;  ph_in = PH_IDLE;
                  end else begin
                     hsign_in = acc_leb[0];
                     ph_in = PH_BMAG;  left_in = mag[3:0];  acc_in = '0;  shift_in = '0;
                  end
               end
               PH_SSTR, PH_SNAME: begin
                  push.first_valid = 1'b1;
                  push.first = make_event(EV_STRBYTE, 64'(b), '0, 1'b0, nm, ERR_INCOMPLETE);
                  left_in = left_dec;
                  if (left_dec == 4'd0) begin
                     push.second_valid = 1'b1;
                     push.second = make_event(EV_STREND, '0, '0, 1'b0, nm, ERR_INCOMPLETE);
                     if (nm) begin
                        expn_in = 1'b0;  ph_in = PH_IDLE;
                     end else
                        vdone = 1'b1;
                  end
               end
               PH_LSTR, PH_LNAME: begin
                  push.first_valid = 1'b1;
                  if (b != TC_LSTR)
                     push.first = make_event(EV_STRBYTE, 64'(b), '0, 1'b0, nm,
                                             ERR_INCOMPLETE);
                  else begin
                     push.first = make_event(EV_STREND, '0, '0, 1'b0, nm, ERR_INCOMPLETE);
                     if (nm) begin
                        expn_in = 1'b0;  ph_in = PH_IDLE;
                     end else
                        vdone = 1'b1;
                  end
               end
               default: ph_in = PH_IDLE;
            endcase
            if (vdone) begin
               ph_in = PH_IDLE;
               if (depth_ff == '0)
                  done_in = 1'b1;
               else if (top_ff)
                  expn_in = 1'b1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ph_ff <= PH_IDLE;  left_ff <= '0;  acc_ff <= '0;  shift_ff <= '0;
         hexp_ff <= '0;  hsign_ff <= 1'b0;  depth_ff <= '0;  expn_ff <= 1'b0;
         started_ff <= 1'b0;  done_ff <= 1'b0;  err_ff <= 1'b0;  top_ff <= 1'b0;
      end else begin
         ph_ff <= ph_in;  left_ff <= left_in;  acc_ff <= acc_in;  shift_ff <= shift_in;
         hexp_ff <= hexp_in;  hsign_ff <= hsign_in;  depth_ff <= depth_in;
         expn_ff <= expn_in;  started_ff <= started_in;  done_ff <= done_in;
         err_ff <= err_in;  top_ff <= top_in;
      end
   end

   // Container kind stack; the entry below the top is kept read ahead.
   always_ff @(posedge clock) begin
      if (stack_we)
         stack_mem[depth_ff[STACK_AW-1:0]] <= stack_wd;
      under_ff <= stack_mem[under_addr[STACK_AW-1:0]];
   end

   assert property (@(posedge clock) disable iff (reset) depth_ff <= DEPTH_W'(MAX_DEPTH))
      else $error("nesting depth beyond stack size");
   assert property (@(posedge clock) disable iff (reset)
      push.second_valid |-> push.first_valid && push.first.event_res == EV_STRBYTE)
      else $error("second event without a string byte first");
   assert property (@(posedge clock) disable iff (reset)
      err_ff |-> ph_ff == PH_IDLE)
      else $error("token in progress after an error");

endmodule

>>> src/bjsd_queue.sv
// Short event queue between front and back; takes up to two events a cycle.
// Depends on bjsd_pkg.
`timescale 1ns / 1ps
module bjsd_queue
   import bjsd_pkg::*;
(
   input  logic     clock,
   input  logic     reset,
   input  push_type push,
   output logic     room,
   input  logic     pop,
   output logic     not_empty,
   output rsp_type  head
);

   rsp_type             slot_ff [QUEUE_DEPTH];
   logic [QUEUE_AW-1:0] wr_ff, rd_ff;
   logic [QUEUE_AW:0]   cnt_ff;
   logic [QUEUE_AW-1:0] wr_next;
   logic [QUEUE_AW:0]   n_push;

   assign room      = cnt_ff <= (QUEUE_AW+1)'(QUEUE_DEPTH - 2);
   assign not_empty = cnt_ff != '0;
   assign head      = slot_ff[rd_ff];
   assign wr_next   = wr_ff + QUEUE_AW'(1);
   assign n_push    = (QUEUE_AW+1)'(push.first_valid) + (QUEUE_AW+1)'(push.second_valid);

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff <= '0;  rd_ff <= '0;  cnt_ff <= '0;
      end else begin
         wr_ff  <= wr_ff + n_push[QUEUE_AW-1:0];
         rd_ff  <= rd_ff + QUEUE_AW'(pop);
         cnt_ff <= cnt_ff + n_push - (QUEUE_AW+1)'(pop);
      end
   end

   always_ff @(posedge clock) begin
      if (push.first_valid)
         slot_ff[wr_ff] <= push.first;
      if (push.second_valid)
         slot_ff[wr_next] <= push.second;
   end

   assert property (@(posedge clock) disable iff (reset)
      cnt_ff <= (QUEUE_AW+1)'(QUEUE_DEPTH))
      else $error("event queue overfilled");
   assert property (@(posedge clock) disable iff (reset) pop |-> not_empty)
      else $error("event queue read while empty");
   assert property (@(posedge clock) disable iff (reset) push.first_valid |-> room)
      else $error("event pushed without room");

endmodule

>>> src/bjsd_back.sv
// Back end of the decoder: output register that presents one event a cycle while rsp_stall is low.
// Depends on bjsd_pkg; drains bjsd_queue.
`timescale 1ns / 1ps
module bjsd_back
   import bjsd_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    not_empty,
   input  rsp_type head,
   output logic    pop,
   output logic    rsp_valid,
   input  logic    rsp_stall,
   output rsp_type rsp_item
);

   logic    valid_ff;
   rsp_type item_ff;
   logic    load;

   assign load      = !valid_ff || !rsp_stall;
   assign pop       = load && not_empty;
   assign rsp_valid = valid_ff;
   assign rsp_item  = item_ff;

   always_ff @(posedge clock) begin
      if (reset)
         valid_ff <= 1'b0;
      else if (load)
         valid_ff <= not_empty;
   end

   always_ff @(posedge clock) begin
      if (pop)
         item_ff <= head;
   end

   assert property (@(posedge clock) disable iff (reset)
      valid_ff && rsp_stall |=> valid_ff && $stable(item_ff))
      else $error("stalled event changed");
   assert property (@(posedge clock) disable iff (reset) pop |=> valid_ff)
      else $error("popped event not presented");
   assert property (@(posedge clock) disable iff (reset)
      !valid_ff |-> !rsp_stall || !pop || not_empty)
      else $error("pop without data");

endmodule

>>> src/binary_json_stream_decoder.sv
// Top level of the binary JSON stream decoder: front parser, event queue, output stage.
// Depends on bjsd_pkg, bjsd_front, bjsd_queue and bjsd_back.
//
//   Channel   Ports                                  Direction  Moves
//   request   req_valid, req_stall, req_item         in         one byte or end marker
//   response  rsp_valid, rsp_stall, rsp_item         out        one decoder event
//   control   csr_wr_en, csr_wr_data                 in         depth limit register
//
// The front takes one item every cycle while the event queue has room for two events.
// A string byte that ends a short string makes two events; the output stage drains one
// event per cycle, so a run of such bytes can fill the queue and stall the input.
// An accepted item's first event is registered in the queue and then in the output stage.
// Reset is synchronous and active high; the depth limit returns to 256.
// A stall on the response side fills the queue and then raises req_stall.
`timescale 1ns / 1ps
module binary_json_stream_decoder
   import bjsd_pkg::*;
(
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_stall,
   input  req_type            req_item,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output rsp_type            rsp_item,
   input  logic               csr_wr_en,
   input  logic [LIMIT_W-1:0] csr_wr_data
);

   logic [LIMIT_W-1:0] limit_ff;
   logic               fire;
   logic               room;
   logic               pop;
   logic               not_empty;
   push_type           push;
   rsp_type            head;

   // An item is taken only when the queue can absorb the two events it may cause.
   assign req_stall = !room;
   assign fire      = req_valid && room;

   always_ff @(posedge clock) begin
      if (reset)
         limit_ff <= LIMIT_W'(256);
      else if (csr_wr_en)
         limit_ff <= csr_wr_data;
   end

   bjsd_front u_front (
      .clock       (clock),
      .reset       (reset),
      .fire        (fire),
      .item        (req_item),
      .depth_limit (limit_ff),
      .push        (push)
   );

   bjsd_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .room      (room),
      .pop       (pop),
      .not_empty (not_empty),
      .head      (head)
   );

   bjsd_back u_back (
      .clock     (clock),
      .reset     (reset),
      .not_empty (not_empty),
      .head      (head),
      .pop       (pop),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_item  (rsp_item)
   );

endmodule

>>> tb/sv/binary_json_stream_decoder_tb.sv
// Self-checking testbench for binary_json_stream_decoder: drives byte and end items,
// predicts every decoder event and checks the event stream. Depends on bjsd_pkg and the RTL.
`timescale 1ns / 1ps
module binary_json_stream_decoder_tb;
   import bjsd_pkg::*;

   // Type codes that the package does not name.
   localparam logic [7:0] TC_INVALID = 8'hc9;
   localparam logic [7:0] TC_STR_MAX = 8'hdf;
   localparam logic [7:0] TC_UINT1   = 8'he0;
   localparam logic [7:0] TC_SINT1   = 8'he4;
   localparam logic [7:0] TC_INT_MAX = 8'he7;
   localparam int CYCLE_LIMIT = 600000;
   localparam int DRAIN_CYCLES = 12;

   typedef enum logic [3:0] {
      TP_IDLE, TP_UINT, TP_SINT, TP_F32, TP_F64, TP_BEXP, TP_BLEN, TP_BMAG,
      TP_SSTR, TP_LSTR, TP_SNAME, TP_LNAME
   } token_phase_type;

   logic clock;
   logic reset;
   logic req_valid;
   logic req_stall;
   req_type req_item;
   logic rsp_valid;
   logic rsp_stall;
   rsp_type rsp_item;
   logic csr_wr_en;
   logic [LIMIT_W-1:0] csr_wr_data;

   binary_json_stream_decoder dut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_stall(req_stall), .req_item(req_item),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp_item(rsp_item),
      .csr_wr_en(csr_wr_en), .csr_wr_data(csr_wr_data)
   );

   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   // Items waiting for the driver, events waiting for the decoder, and counters.
   req_type pending_items[$];
   rsp_type expected_events[$];
   logic [7:0] doc_bytes[$];
   int mismatches = 0;
   int items_sent = 0;
   int events_seen = 0;
   int docs_built = 0;
   int cycles = 0;
   bit quiet_mode = 0;      // When set, neither side adds random gaps.
   int rsp_hold = 0;        // Long receiver hold-off, counted down by the monitor.

   // Decoder image used to predict events.
   int unsigned limit_reg = 256;
   token_phase_type tphase;
   int unsigned count_left;
   logic [63:0] acc;
   int unsigned shift_pos;
   logic [31:0] big_exp;
   logic big_neg;
   bit level_obj[0:MAX_DEPTH-1];
   int unsigned nest;
   bit want_name;
   bit doc_started, doc_done, doc_error;

   task automatic add_event(input logic [3:0] ev, input logic [63:0] val,
                            input logic [31:0] ex, input logic neg, input logic nm,
                            input logic [3:0] code);
      rsp_type r;
      r.event_res = ev;
      r.value = val;
      r.exponent = ex;
      r.negative = neg;
      r.is_name = nm;
      r.error_code = code;
      expected_events.push_back(r);
   endtask

   task automatic raise_error(input logic [3:0] code);
      add_event(EV_ERROR, 64'd0, 32'd0, 1'b0, 1'b0, code);
      doc_error = 1;
      tphase = TP_IDLE;
   endtask

   task automatic clear_doc();
      tphase = TP_IDLE;
      count_left = 0;
      acc = '0;
      shift_pos = 0;
      big_exp = '0;
      big_neg = 0;
      for (int i = 0; i < MAX_DEPTH; i++) level_obj[i] = 0;
      nest = 0;
      want_name = 0;
      doc_started = 0;
      doc_done = 0;
      doc_error = 0;
   endtask

   // A value has finished: the top level is complete or an object wants its next name.
   task automatic finish_value();
      tphase = TP_IDLE;
      if (nest == 0) doc_done = 1;
      else if (level_obj[nest-1]) want_name = 1;
   endtask

   task automatic begin_fixed(input token_phase_type p, input int unsigned n);
      tphase = p;
      count_left = n;
      acc = '0;
      shift_pos = 0;
   endtask

   // Returns 0 while more LEB128 bytes follow, 1 when complete, 2 on overflow.
   function automatic int take_leb(input logic [7:0] b);
      acc |= 64'(b[6:0]) << shift_pos;
      if (!b[7]) return 1;
      shift_pos += 7;
      if (shift_pos >= 64) return 2;
      return 0;
   endfunction

   task automatic open_container(input bit obj);
      int unsigned lim;
      lim = (limit_reg > MAX_DEPTH) ? MAX_DEPTH : limit_reg;
      if (nest >= lim) begin
         raise_error(ERR_TOO_DEEP);
      end else begin
         level_obj[nest] = obj;
         nest++;
         want_name = obj;
         add_event(obj ? EV_OBJ : EV_ARR, 64'd0, 32'd0, 1'b0, 1'b0, 4'd0);
      end
   endtask

   task automatic close_container();
      if (nest == 0) begin
         raise_error(ERR_UNBALANCED);
      end else if (level_obj[nest-1] && !want_name) begin
         raise_error(ERR_NEED_VALUE);
      end else begin
         nest--;
         add_event(EV_END, 64'd0, 32'd0, 1'b0, 1'b0, 4'd0);
         want_name = 0;
         if (nest == 0) doc_done = 1;
         else if (level_obj[nest-1]) want_name = 1;
      end
   endtask

   // First byte of a token.
   task automatic start_token(input logic [7:0] b);
      if (b == TC_CEND) begin
         close_container();
      end else if (nest > 0 && level_obj[nest-1] && want_name) begin
         if (b == TC_STR0) begin
            add_event(EV_STREND, 64'd0, 32'd0, 1'b0, 1'b1, 4'd0);
            want_name = 0;
         end else if (b > TC_STR0 && b <= TC_STR_MAX) begin
            begin_fixed(TP_SNAME, b - TC_STR0);
         end else if (b == TC_LSTR) begin
            tphase = TP_LNAME;
         end else begin
            raise_error(ERR_NEED_NAME);
         end
      end else if (b <= TC_SMALL_MAX) begin
         add_event(EV_SINT, 64'(b) - 64'd100, 32'd0, 1'b0, 1'b0, 4'd0);
         finish_value();
      end else if (b == TC_BIGNUM) begin
         begin_fixed(TP_BEXP, 0);
      end else if (b == TC_F32) begin
         begin_fixed(TP_F32, 4);
      end else if (b == TC_F64) begin
         begin_fixed(TP_F64, 8);
      end else if (b == TC_NULL || b == TC_FALSE || b == TC_TRUE) begin
         add_event(b == TC_NULL ? EV_NULL : EV_BOOL, {63'd0, b == TC_TRUE},
                   32'd0, 1'b0, 1'b0, 4'd0);
         finish_value();
      end else if (b == TC_ARRAY || b == TC_OBJECT) begin
         open_container(b == TC_OBJECT);
      end else if (b == TC_LSTR) begin
         tphase = TP_LSTR;
      end else if (b == TC_STR0) begin
         add_event(EV_STREND, 64'd0, 32'd0, 1'b0, 1'b0, 4'd0);
         finish_value();
      end else if (b > TC_STR0 && b <= TC_STR_MAX) begin
         begin_fixed(TP_SSTR, b - TC_STR0);
      end else if (b >= TC_UINT1 && b <= TC_INT_MAX) begin
         begin_fixed(b < TC_SINT1 ? TP_UINT : TP_SINT, 1 << b[1:0]);
      end else begin
         raise_error(ERR_INVALID);
      end
   endtask

   // Byte of a fixed-size payload: integer, float or big number magnitude.
   task automatic fixed_payload(input logic [7:0] b);
      acc |= 64'(b) << (shift_pos & 63);
      shift_pos += 8;
      if (count_left > 0) count_left--;
      if (count_left == 0) begin
         case (tphase)
            TP_UINT: begin
               add_event(EV_UINT, acc, 32'd0, 1'b0, 1'b0, 4'd0);
               finish_value();
            end
            TP_SINT: begin
               if (shift_pos < 64 && acc[shift_pos-1]) acc |= ~64'd0 << shift_pos;
               add_event(EV_SINT, acc, 32'd0, 1'b0, 1'b0, 4'd0);
               finish_value();
            end
            TP_F32: begin
               if (acc[30:23] == 8'hff) begin
                  raise_error(ERR_INVALID);
               end else begin
                  add_event(EV_F32, acc, 32'd0, 1'b0, 1'b0, 4'd0);
                  finish_value();
               end
            end
            TP_F64: begin
               if (acc[62:52] == 11'h7ff) begin
                  raise_error(ERR_INVALID);
               end else begin
                  add_event(EV_F64, acc, 32'd0, 1'b0, 1'b0, 4'd0);
                  finish_value();
               end
            end
            default: begin
               // A big number whose top magnitude byte is zero is not normalized.
               if (b == 8'd0) begin
                  raise_error(ERR_INVALID);
               end else begin
                  add_event(EV_BIGNUM, acc, big_exp, big_neg, 1'b0, 4'd0);
                  finish_value();
               end
            end
         endcase
      end
   endtask

   task automatic string_done(input bit nm);
      if (nm) begin
         want_name = 0;
         tphase = TP_IDLE;
      end else begin
         finish_value();
      end
   endtask

   // Works out the events that one accepted item causes.
   task automatic predict_events(input req_type it);
      logic [7:0] b;
      int r;
      logic [63:0] z, mag;
      bit nm;
      b = it.data_byte;
      if (it.kind) begin
         if (doc_error) ;
         else if (!doc_started) raise_error(ERR_EMPTY);
         else if (doc_done) add_event(EV_DONE, 64'd0, 32'd0, 1'b0, 1'b0, 4'd0);
         else if (tphase != TP_IDLE) raise_error(ERR_INCOMPLETE);
         else if (nest > 0) raise_error(ERR_UNCLOSED);
         else raise_error(ERR_INCOMPLETE);
         clear_doc();
      end else if (doc_error) begin
         // Bytes after an error are dropped until the end marker.
      end else if (doc_done) begin
         raise_error(ERR_TRAILING);
      end else begin
         doc_started = 1;
         case (tphase)
            TP_IDLE: start_token(b);
            TP_UINT, TP_SINT, TP_F32, TP_F64, TP_BMAG: fixed_payload(b);
            TP_BEXP: begin
               r = take_leb(b);
               if (r == 2) begin
                  raise_error(ERR_RANGE);
               end else if (r == 1) begin
                  z = acc;
                  big_exp = 32'((z >> 1) ^ (64'd0 - (z & 64'd1)));
                  begin_fixed(TP_BLEN, 0);
               end
            end
            TP_BLEN: begin
               r = take_leb(b);
               if (r == 2) begin
                  raise_error(ERR_RANGE);
               end else if (r == 1) begin
                  z = acc;
                  mag = z[0] ? (z >> 1) + 64'd1 : (z >> 1);
                  if (mag == 0) begin
                     add_event(EV_BIGNUM, 64'd0, big_exp, 1'b0, 1'b0, 4'd0);
                     finish_value();
                  end else if (mag > 8) begin
                     raise_error(ERR_RANGE);
                  end else begin
                     big_neg = z[0];
                     begin_fixed(TP_BMAG, int'(mag));
                  end
               end
            end
            TP_SSTR, TP_SNAME: begin
               nm = (tphase == TP_SNAME);
               add_event(EV_STRBYTE, 64'(b), 32'd0, 1'b0, nm, 4'd0);
               if (count_left > 0) count_left--;
               if (count_left == 0) begin
                  add_event(EV_STREND, 64'd0, 32'd0, 1'b0, nm, 4'd0);
                  string_done(nm);
               end
            end
            default: begin
               nm = (tphase == TP_LNAME);
               if (b != TC_LSTR) begin
                  add_event(EV_STRBYTE, 64'(b), 32'd0, 1'b0, nm, 4'd0);
               end else begin
                  add_event(EV_STREND, 64'd0, 32'd0, 1'b0, nm, 4'd0);
                  string_done(nm);
               end
            end
         endcase
      end
   endtask

   // Gap length: mostly none, sometimes short, now and then long.
   function automatic int pick_gap();
      int r;
      r = $urandom_range(0, 99);
      if (quiet_mode || r < 60) return 0;
      if (r < 90) return $urandom_range(1, 3);
      return $urandom_range(8, 40);
   endfunction

   // Driver: presents queued items, holds a stalled item steady, and feeds the predictor.
   int send_gap = 0;
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
         req_item <= '0;
      end else begin
         if (req_valid && !req_stall) begin
            predict_events(req_item);
            items_sent++;
         end
         if (!req_valid || !req_stall) begin
            if (send_gap > 0) begin
               send_gap <= send_gap - 1;
               req_valid <= 1'b0;
            end else if (pending_items.size() > 0) begin
               req_item <= pending_items.pop_front();
               req_valid <= 1'b1;
               send_gap <= pick_gap();
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   task automatic report(input string what, input logic [63:0] got, input logic [63:0] want);
      mismatches++;
      $display("mismatch at event %0d: %s got %0h expected %0h", events_seen, what, got, want);
   endtask

   // Monitor: randomly stalls, honors the long hold-off, and checks each accepted event.
   int stall_left = 0;
   always @(posedge clock) begin
      rsp_type want;
      if (reset) begin
         rsp_stall <= 1'b0;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            if (expected_events.size() == 0) begin
               report("unexpected event", 64'(rsp_item.event_res), 64'd0);
            end else begin
               want = expected_events.pop_front();
               if (rsp_item.event_res !== want.event_res)
                  report("event_res", 64'(rsp_item.event_res), 64'(want.event_res));
               if (rsp_item.value !== want.value)
                  report("value", rsp_item.value, want.value);
               if (rsp_item.exponent !== want.exponent)
                  report("exponent", 64'(rsp_item.exponent), 64'(want.exponent));
               if (rsp_item.negative !== want.negative)
                  report("negative", 64'(rsp_item.negative), 64'(want.negative));
               if (rsp_item.is_name !== want.is_name)
                  report("is_name", 64'(rsp_item.is_name), 64'(want.is_name));
               if (rsp_item.error_code !== want.error_code)
                  report("error_code", 64'(rsp_item.error_code), 64'(want.error_code));
            end
            events_seen++;
         end
         if (rsp_hold > 0) begin
            rsp_hold <= rsp_hold - 1;
            rsp_stall <= 1'b1;
         end else if (stall_left > 0) begin
            stall_left <= stall_left - 1;
            rsp_stall <= 1'b1;
         end else begin
            rsp_stall <= 1'b0;
            stall_left <= pick_gap();
         end
      end
   end

   always @(posedge clock) begin
      cycles++;
      if (cycles > CYCLE_LIMIT) begin
         $display("timeout with %0d events still expected", expected_events.size());
         $display("[FAIL] regression broken");
         $finish;
      end
   end

   task automatic add_byte(input logic [7:0] b);
      req_type it;
      it.kind = 1'b0;
      it.data_byte = b;
      pending_items.push_back(it);
   endtask

   task automatic add_end();
      req_type it;
      it.kind = 1'b1;
      it.data_byte = 8'($urandom);
      pending_items.push_back(it);
   endtask

   task automatic gen_leb(input int n, input bit overflow);
      for (int i = 0; i < n; i++)
         doc_bytes.push_back({overflow || (i < n - 1), 7'($urandom)});
   endtask

   task automatic gen_string(input bit name_only);
      int n;
      if ($urandom_range(0, 3) == 0) begin
         doc_bytes.push_back(TC_LSTR);
         n = $urandom_range(0, 5);
         for (int i = 0; i < n; i++) doc_bytes.push_back(8'($urandom_range(0, 254)));
         doc_bytes.push_back(TC_LSTR);
      end else begin
         n = $urandom_range(0, 15);
         doc_bytes.push_back(TC_STR0 + 8'(n));
         for (int i = 0; i < n; i++) doc_bytes.push_back(8'($urandom));
      end
   endtask

   // Appends one value, mostly well-formed, with containers nested at most four deep.
   task automatic gen_value(input int lvl);
      int r, n, len;
      logic [7:0] b;
      r = $urandom_range(0, 99);
      if (r < 12) begin
         doc_bytes.push_back(8'($urandom_range(0, TC_SMALL_MAX)));
      end else if (r < 20) begin
         doc_bytes.push_back(TC_NULL + 8'($urandom_range(0, 2)));
      end else if (r < 32) begin
         n = $urandom_range(0, 3);
         doc_bytes.push_back(($urandom_range(0, 1) ? TC_SINT1 : TC_UINT1) + 8'(n));
         for (int i = 0; i < (1 << n); i++) doc_bytes.push_back(8'($urandom));
      end else if (r < 42) begin
         n = $urandom_range(0, 1) ? 8 : 4;
         doc_bytes.push_back(n == 8 ? TC_F64 : TC_F32);
         for (int i = 0; i < n; i++) begin
            b = 8'($urandom);
            // Now and then force the exponent field to all ones.
            if (i >= n - 2 && $urandom_range(0, 7) == 0) b = b | (i == n - 1 ? 8'h7f : 8'hf0);
            doc_bytes.push_back(b);
         end
      end else if (r < 54) begin
         doc_bytes.push_back(TC_BIGNUM);
         if ($urandom_range(0, 15) == 0) gen_leb(10, 1);
         else gen_leb($urandom_range(1, 4), 0);
         len = $urandom_range(0, 15) == 0 ? $urandom_range(9, 12) : $urandom_range(0, 8);
         if (len == 0 || $urandom_range(0, 1)) doc_bytes.push_back(8'(2 * len));
         else doc_bytes.push_back(8'(2 * len - 1));
         for (int i = 0; i < len && i < 8; i++) begin
            b = 8'($urandom);
            if (i == len - 1 && b == 0 && $urandom_range(0, 3) != 0) b = 8'd1;
            doc_bytes.push_back(b);
         end
      end else if (r < 68) begin
         gen_string(0);
      end else if (r < 84 && lvl < 4) begin
         doc_bytes.push_back(TC_ARRAY);
         n = $urandom_range(0, 3);
         for (int i = 0; i < n; i++) gen_value(lvl + 1);
         doc_bytes.push_back(TC_CEND);
      end else if (lvl < 4) begin
         doc_bytes.push_back(TC_OBJECT);
         n = $urandom_range(0, 3);
         for (int i = 0; i < n; i++) begin
            gen_string(1);
            gen_value(lvl + 1);
         end
         doc_bytes.push_back(TC_CEND);
      end else begin
         doc_bytes.push_back(TC_TRUE);
      end
   endtask

   // One document, usually intact, otherwise cut short, corrupted, trailed or pure noise.
   task automatic gen_document();
      int m, pos, n;
      doc_bytes.delete();
      gen_value(0);
      m = $urandom_range(0, 99);
      if (m < 70) ;
      else if (m < 78) begin
         pos = $urandom_range(0, doc_bytes.size() - 1);
         while (doc_bytes.size() > pos) void'(doc_bytes.pop_back());
      end else if (m < 86) begin
         doc_bytes[$urandom_range(0, doc_bytes.size() - 1)] = 8'($urandom);
      end else if (m < 92) begin
         doc_bytes.push_back(8'($urandom));
      end else begin
         doc_bytes.delete();
         n = $urandom_range(0, 6);
         for (int i = 0; i < n; i++) doc_bytes.push_back(8'($urandom));
      end
      foreach (doc_bytes[i]) add_byte(doc_bytes[i]);
      add_end();
      docs_built++;
   endtask

   task automatic gen_random(input int count);
      int target;
      target = items_sent + pending_items.size() + count;
      while (items_sent + pending_items.size() < target) gen_document();
   endtask

   task automatic gen_nesting(input int levels);
      for (int i = 0; i < levels; i++) add_byte(TC_ARRAY);
      for (int i = 0; i < levels; i++) add_byte(TC_CEND);
      add_end();
   endtask

   // Waits until every item has gone in and every event has come out, then lets the
   // pipeline settle so that items without events have also passed.
   task automatic wait_quiet();
      while (pending_items.size() != 0 || req_valid || expected_events.size() != 0)
         @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic set_depth_limit(input logic [LIMIT_W-1:0] v);
      wait_quiet();
      @(posedge clock);
      csr_wr_en <= 1'b1;
      csr_wr_data <= v;
      @(posedge clock);
      csr_wr_en <= 1'b0;
      limit_reg = v;
   endtask

   initial begin
      reset = 1'b1;
      csr_wr_en = 1'b0;
      csr_wr_data = '0;
      req_valid = 1'b0;
      req_item = '0;
      rsp_stall = 1'b0;
      clear_doc();
      repeat (5) @(posedge clock);
      reset <= 1'b0;

      // Directed: empty document, small int extremes, literals, stray end, invalid code,
      // widest signed integer, zero-length strings, trailing data and a too-short float.
      add_end();
      add_byte(8'h00); add_end();
      add_byte(TC_SMALL_MAX); add_end();
      add_byte(TC_TRUE); add_end();
      add_byte(TC_CEND); add_end();
      add_byte(TC_INVALID); add_byte(8'h55); add_end();
      add_byte(TC_INT_MAX);
      for (int i = 0; i < 8; i++) add_byte(8'hff);
      add_end();
      add_byte(TC_OBJECT); add_byte(TC_STR0); add_byte(TC_STR0); add_byte(TC_CEND);
      add_end();
      add_byte(TC_NULL); add_byte(TC_FALSE); add_end();
      add_byte(TC_F32); add_byte(8'h00); add_end();
      wait_quiet();

      // Full-depth nesting at the default limit, then random documents.
      gen_nesting(MAX_DEPTH);
      gen_random(150);

      set_depth_limit(9'd1);
      gen_random(120);
      set_depth_limit(9'd0);
      gen_random(80);

      // The receiver holds off for a long stretch while the sender keeps offering items.
      set_depth_limit(9'd3);
      quiet_mode = 1;
      rsp_hold = 400;
      gen_random(150);
      wait_quiet();
      quiet_mode = 0;

      // A limit above the stack size is clamped to it, so one level past the stack is refused.
      set_depth_limit(9'h1ff);
      for (int i = 0; i <= MAX_DEPTH; i++) add_byte(TC_ARRAY);
      add_end();
      gen_random(120);
      set_depth_limit(9'(MAX_DEPTH));
      gen_random(80);
      set_depth_limit(9'd2);
      gen_random(50);

      wait_quiet();
      repeat (DRAIN_CYCLES) @(posedge clock);
      $display("covered %0d items in %0d documents, %0d events checked, %0d mismatches",
               items_sent, docs_built, events_seen, mismatches);
      $display("depth limits 0, 1, 2, 3, 256 and 511 with a long output hold-off");
      if (mismatches == 0 && expected_events.size() == 0) begin
         $display("[ OK ] regression clean");
      end else begin
         $display("[FAIL] regression broken");
      end
      $finish;
   end

endmodule
